@@ hdl/raycast_ray_setup_macros.svh @@
// Assertion macros for the ray setup block
`ifndef RAYCAST_RAY_SETUP_MACROS_SVH
`define RAYCAST_RAY_SETUP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl");
`define RRS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lbl");
`else
`define RRS_ASSERT(lbl, clk, rst_n, prop)
`define RRS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ hdl/rrs_pkg.sv @@
package rrs_pkg;
    localparam int ScreenWidth = 640;
    localparam int MapDim      = 64;
    localparam logic [23:0] Sat24 = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_ROTATE  = 2'd0,
        KIND_CAST    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_ROT_COS     = 3'd0,
        REG_ROT_SIN     = 3'd1,
        REG_START_DIR_X = 3'd2,
        REG_START_DIR_Y = 3'd3,
        REG_START_PLN_X = 3'd4,
        REG_START_PLN_Y = 3'd5
    } t_reg_idx;

    // control from sequencer to the serial divider
    typedef struct packed {
        logic        start;
        logic [45:0] dividend;
        logic [35:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quot;   // saturated
    } t_div_rsp;
endpackage

@@ hdl/rrs_div.sv @@
// Restoring radix-2 divider: one quotient bit per cycle, saturates to 24 bits.
module rrs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrs_pkg::t_div_req i_req,
    output rrs_pkg::t_div_rsp o_rsp
);
    `include "raycast_ray_setup_macros.svh"

    logic [45:0] r_dvd;
    logic [35:0] r_rem;
    logic [35:0] r_dsr;
    logic [45:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [36:0] w_trial;
    logic [36:0] w_sub;

    // shift one dividend bit into the partial remainder
    assign w_trial = {r_rem, r_dvd[45]};
    assign w_sub   = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd46;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[44:0], 1'b0};
                // remainder stays below the divisor, so bit 36 is free
                if (!w_sub[36]) begin
                    r_rem <= w_sub[35:0];
                    r_q   <= {r_q[44:0], 1'b1};
                end else begin
                    r_rem <= w_trial[35:0];
                    r_q   <= {r_q[44:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_q[45:24] != '0) ? rrs_pkg::Sat24 : r_q[23:0];

    `RRS_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `RRS_ASSERT(a_cnt_idle, i_clk, i_rst_n, !r_busy |-> (r_cnt == 6'd0))
    `RRS_ASSERT(a_no_restart, i_clk, i_rst_n, r_busy |-> !i_req.start)
endmodule

@@ hdl/rrs_mul.sv @@
// Serial signed multiplier: 16-bit signed by 16-bit signed, two multiplier bits a cycle.
module rrs_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic               o_done,
    output logic signed [31:0] o_prod
);
    `include "raycast_ray_setup_macros.svh"

    logic signed [31:0] r_acc;
    logic signed [31:0] r_mcand;
    logic [15:0]        r_mplr;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [31:0] w_p0;
    logic signed [31:0] w_p1;

    // top bit of a two's complement multiplier carries negative weight
    always_comb begin
        w_p0 = r_mplr[0] ? r_mcand : 32'sd0;
        w_p1 = r_mplr[1] ? (r_mcand <<< 1) : 32'sd0;
        if (r_cnt == 4'd1) begin
            w_p1 = -w_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 4'd8;
                r_acc   <= '0;
                r_mcand <= 32'(i_a);
                r_mplr  <= i_b;
            end else if (r_busy) begin
                r_acc   <= r_acc + w_p0 + w_p1;
                r_mcand <= r_mcand <<< 2;
                r_mplr  <= {2'b00, r_mplr[15:2]};
                r_cnt   <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ hdl/raycast_ray_setup.sv @@
// Ray setup for a grid raycaster. Holds the view direction and camera plane
// (Q2.14); a rotate request turns both by the configured cosine and sine
// (right first, then left), a restart request reloads both from the start registers, and
// a cast request gives the map cell, step signs, delta and side distances
// (Q8.16, saturating) for one screen column. Requests are handled one at a
// time. A rotate computes eight products per key through a two-bit-per-cycle
// serial multiplier, each pair summed and rounded to Q2.14. A cast computes
// four products, then four divisions (46 steps each) through one shared
// bit-serial divider; a division by a zero ray component skips the divider.
// Restart and the unused kind need no arithmetic. Every request then passes
// through ST_OUT, which loads the output register; that register holds the
// result until taken, and no new request is accepted while it is full.
module raycast_ray_setup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_turn_right,
    input  logic        i_turn_left,
    input  logic [9:0]  i_column,
    input  logic [21:0] i_pos_x,
    input  logic [21:0] i_pos_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_cell_x,
    output logic [5:0]  o_cell_y,
    output logic        o_step_x_neg,
    output logic        o_step_y_neg,
    output logic [23:0] o_delta_x,
    output logic [23:0] o_delta_y,
    output logic [23:0] o_side_x,
    output logic [23:0] o_side_y,
    output logic signed [15:0] o_view_dir_x,
    output logic signed [15:0] o_view_dir_y,
    output logic signed [15:0] o_view_plane_x,
    output logic signed [15:0] o_view_plane_y
);
    `include "raycast_ray_setup_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROT_MUL, ST_ROT_WAIT, ST_ROT_DONE,
        ST_CAST_MUL, ST_CAST_WAIT, ST_DIV, ST_DIV_WAIT, ST_OUT
    } t_state;

    localparam logic signed [15:0] OffW = 16'(rrs_pkg::ScreenWidth);

    t_state r_state;
    logic signed [15:0] r_cfg [6];
    logic signed [15:0] r_dx, r_dy, r_px, r_py;
    logic signed [15:0] r_ndx, r_ndy, r_npx;
    logic        r_right, r_left, r_sub_neg;
    logic [9:0]  r_col;
    logic [21:0] r_posx, r_posy;
    logic [2:0]  r_midx;        // product index within a step
    logic signed [36:0] r_sum;
    logic signed [36:0] r_numx, r_numy;
    logic [1:0]  r_didx;
    logic [23:0] r_dlx, r_dly, r_sdx, r_sdy;
    logic        r_ovalid;
    logic        r_cast;

    logic               w_mstart;
    logic signed [15:0] w_ma, w_mb;
    logic               w_mdone;
    logic signed [31:0] w_prod;
    rrs_pkg::t_div_req  w_dreq;
    rrs_pkg::t_div_rsp  w_drsp;
    logic signed [15:0] w_q14;
    logic signed [15:0] w_coff;

    rrs_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
                   .o_done(w_mdone), .o_prod(w_prod));
    rrs_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));

    // camera offset 2*column - W
    assign w_coff = 16'({6'd0, r_col} << 1) - OffW;

    // operand select for the shared multiplier; sine products are signed later
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_ROT_MUL) begin
            unique case (r_midx)
                3'd0: begin w_ma = r_dx; w_mb = r_cfg[rrs_pkg::REG_ROT_COS]; end
                3'd1: begin w_ma = r_dy; w_mb = r_cfg[rrs_pkg::REG_ROT_SIN]; end
                3'd2: begin w_ma = r_dx; w_mb = r_cfg[rrs_pkg::REG_ROT_SIN]; end
                3'd3: begin w_ma = r_dy; w_mb = r_cfg[rrs_pkg::REG_ROT_COS]; end
                3'd4: begin w_ma = r_px; w_mb = r_cfg[rrs_pkg::REG_ROT_COS]; end
                3'd5: begin w_ma = r_py; w_mb = r_cfg[rrs_pkg::REG_ROT_SIN]; end
                3'd6: begin w_ma = r_px; w_mb = r_cfg[rrs_pkg::REG_ROT_SIN]; end
                default: begin w_ma = r_py; w_mb = r_cfg[rrs_pkg::REG_ROT_COS]; end
            endcase
        end else begin
            unique case (r_midx[1:0])
                2'd0: begin w_ma = r_dx; w_mb = OffW; end
                2'd1: begin w_ma = r_px; w_mb = w_coff; end
                2'd2: begin w_ma = r_dy; w_mb = OffW; end
                default: begin w_ma = r_py; w_mb = w_coff; end
            endcase
        end
    end
    assign w_mstart = (r_state == ST_ROT_MUL) || (r_state == ST_CAST_MUL);

    // sine product sign: -s in x, +s in y on a right turn, mirrored on a left turn
    logic               w_pneg;
    logic signed [36:0] w_pterm;
    always_comb begin
        w_pneg = 1'b0;
        if (r_state == ST_ROT_WAIT) begin
            if (r_midx[1:0] == 2'd1) w_pneg = !r_sub_neg;
            else if (r_midx[1:0] == 2'd2) w_pneg = r_sub_neg;
        end
    end
    assign w_pterm = w_pneg ? -37'(w_prod) : 37'(w_prod);

    // Q4.28 sum to Q2.14: round half up (floor of sum+8192), saturate
    logic signed [36:0] w_rs;
    assign w_rs = r_sum + 37'sd8192;
    always_comb begin
        if ((w_rs >>> 14) > 37'sd32767) w_q14 = 16'sh7FFF;
        else if ((w_rs >>> 14) < -37'sd32768) w_q14 = -16'sh8000;
        else w_q14 = w_rs[29:14];
    end

    // divider operands for delta and side of each axis
    logic [35:0] w_magx, w_magy, w_mag;
    logic [16:0] w_fx, w_fy, w_f;
    assign w_magx = r_numx[36] ? 36'(-r_numx) : r_numx[35:0];
    assign w_magy = r_numy[36] ? 36'(-r_numy) : r_numy[35:0];
    assign w_fx = r_numx[36] ? {1'b0, r_posx[15:0]} : 17'h10000 - {1'b0, r_posx[15:0]};
    assign w_fy = r_numy[36] ? {1'b0, r_posy[15:0]} : 17'h10000 - {1'b0, r_posy[15:0]};
    assign w_mag = r_didx[1] ? w_magy : w_magx;
    assign w_f   = r_didx[1] ? w_fy : w_fx;

    always_comb begin
        w_dreq.start    = (r_state == ST_DIV) && (w_mag != '0);
        w_dreq.divisor  = w_mag;
        w_dreq.dividend = r_didx[0] ? 46'(w_f) * 46'(rrs_pkg::ScreenWidth) << 14
                                    : 46'(rrs_pkg::ScreenWidth) << 30;
    end

    logic [23:0] w_dval;
    assign w_dval = (w_mag == '0) ? ((r_didx[0] && w_f == '0) ? 24'd0 : rrs_pkg::Sat24)
                                  : w_drsp.quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cfg[rrs_pkg::REG_ROT_COS]     <= 16'sd16380;
            r_cfg[rrs_pkg::REG_ROT_SIN]     <= 16'sd360;
            r_cfg[rrs_pkg::REG_START_DIR_X] <= 16'sd16384;
            r_cfg[rrs_pkg::REG_START_DIR_Y] <= 16'sd0;
            r_cfg[rrs_pkg::REG_START_PLN_X] <= 16'sd0;
            r_cfg[rrs_pkg::REG_START_PLN_Y] <= 16'sd10813;
            r_dx <= 16'sd16384;
            r_dy <= 16'sd0;
            r_px <= 16'sd0;
            r_py <= 16'sd10813;
        end else begin
            if (i_cfg_we && i_cfg_idx <= rrs_pkg::REG_START_PLN_Y) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_valid && !r_ovalid) begin
                    r_col <= i_column;
                    r_posx <= i_pos_x;
                    r_posy <= i_pos_y;
                    r_midx <= '0;
                    r_sum  <= '0;
                    r_cast <= 1'b0;
                    unique case (rrs_pkg::t_kind'(i_kind))
                        rrs_pkg::KIND_ROTATE: begin
                            r_right <= i_turn_right;
                            r_left  <= i_turn_left;
                            r_sub_neg <= !i_turn_right;
                            if (i_turn_right || i_turn_left) r_state <= ST_ROT_MUL;
                            else r_state <= ST_OUT;
                        end
                        rrs_pkg::KIND_CAST: begin
                            r_cast <= 1'b1;
                            r_state <= ST_CAST_MUL;
                        end
                        rrs_pkg::KIND_RESTART: begin
                            r_dx <= r_cfg[rrs_pkg::REG_START_DIR_X];
                            r_dy <= r_cfg[rrs_pkg::REG_START_DIR_Y];
                            r_px <= r_cfg[rrs_pkg::REG_START_PLN_X];
                            r_py <= r_cfg[rrs_pkg::REG_START_PLN_Y];
                            r_state <= ST_OUT;
                        end
                        default: r_state <= ST_OUT;
                    endcase
                end
                ST_ROT_MUL: r_state <= ST_ROT_WAIT;
                ST_ROT_WAIT: if (w_mdone) begin
                    if (!r_midx[0]) begin
                        r_sum <= w_pterm;
                        r_midx <= r_midx + 3'd1;
                        r_state <= ST_ROT_MUL;
                    end else begin
                        r_sum <= r_sum + w_pterm;
                        r_state <= ST_ROT_DONE;
                    end
                end
                ST_ROT_DONE: begin
                    unique case (r_midx[2:1])
                        2'd0: r_ndx <= w_q14;
                        2'd1: r_ndy <= w_q14;
                        2'd2: r_npx <= w_q14;
                        default: ;
                    endcase
                    if (r_midx == 3'd7) begin
                        r_dx <= r_ndx; r_dy <= r_ndy; r_px <= r_npx; r_py <= w_q14;
                        r_midx <= '0;
                        if (r_right && r_left && !r_sub_neg) begin
                            r_sub_neg <= 1'b1;
                            r_state <= ST_ROT_MUL;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_midx <= r_midx + 3'd1;
                        r_state <= ST_ROT_MUL;
                    end
                end
                ST_CAST_MUL: r_state <= ST_CAST_WAIT;
                ST_CAST_WAIT: if (w_mdone) begin
                    if (!r_midx[0]) begin
                        r_sum <= 37'(w_prod);
                        r_midx <= r_midx + 3'd1;
                        r_state <= ST_CAST_MUL;
                    end else if (r_midx[1] == 1'b0) begin
                        r_numx <= r_sum + 37'(w_prod);
                        r_midx <= r_midx + 3'd1;
                        r_state <= ST_CAST_MUL;
                    end else begin
                        r_numy <= r_sum + 37'(w_prod);
                        r_didx <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: if (w_drsp.done || w_mag == '0) begin
                    unique case (r_didx)
                        2'd0: r_dlx <= w_dval;
                        2'd1: r_sdx <= w_dval;
                        2'd2: r_dly <= w_dval;
                        default: r_sdy <= w_dval;
                    endcase
                    r_didx <= r_didx + 2'd1;
                    r_state <= (r_didx == 2'd3) ? ST_OUT : ST_DIV;
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // request accepted only when idle and the output register is free
    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    logic [5:0] w_cx, w_cy;
    assign w_cx = (r_posx[21:16] > 6'(rrs_pkg::MapDim - 1)) ? 6'(rrs_pkg::MapDim - 1)
                                                           : r_posx[21:16];
    assign w_cy = (r_posy[21:16] > 6'(rrs_pkg::MapDim - 1)) ? 6'(rrs_pkg::MapDim - 1)
                                                           : r_posy[21:16];
    assign o_cell_x     = r_cast ? w_cx : '0;
    assign o_cell_y     = r_cast ? w_cy : '0;
    assign o_step_x_neg = r_cast & r_numx[36];
    assign o_step_y_neg = r_cast & r_numy[36];
    assign o_delta_x    = r_cast ? r_dlx : '0;
    assign o_delta_y    = r_cast ? r_dly : '0;
    assign o_side_x     = r_cast ? r_sdx : '0;
    assign o_side_y     = r_cast ? r_sdy : '0;
    assign o_view_dir_x   = r_dx;
    assign o_view_dir_y   = r_dy;
    assign o_view_plane_x = r_px;
    assign o_view_plane_y = r_py;

    `RRS_ASSERT(a_ready_idle, i_clk, i_rst_n, o_ready |-> (r_state == ST_IDLE))
    `RRS_ASSERT(a_out_from_st, i_clk, i_rst_n, $rose(r_ovalid) |-> $past(r_state == ST_OUT))
    `RRS_ASSERT(a_out_hold, i_clk, i_rst_n, (r_ovalid && !i_ready) |=> $stable(o_view_dir_x))
    `RRS_ASSERT(a_busy_no_out, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !r_ovalid)
endmodule
